### hdl/wbps_pkg.sv
// Shared constants, types and the per-position compare function of the byte pattern scanner.
package wbps_pkg;

	localparam int PATTERN_MAX    = 32;
	localparam int ADDRESS_BITS   = 48;
	localparam int HIST_DEPTH     = PATTERN_MAX - 1;
	localparam int DIST_BITS      = $clog2(PATTERN_MAX);
	localparam int LEN_BITS       = DIST_BITS + 1;
	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_INDEX_BITS = 3;
	localparam int WORD_BYTES     = 8;
	localparam int PATTERN_WORDS  = PATTERN_MAX / WORD_BYTES;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LENGTH  = 3'd0,
		REG_PATTERN_BYTES_A = 3'd1,
		REG_PATTERN_BYTES_B = 3'd2,
		REG_PATTERN_BYTES_C = 3'd3,
		REG_PATTERN_BYTES_D = 3'd4,
		REG_WILDCARD_MASK   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_BITS-1:0]               eff_len;
		logic [PATTERN_MAX-1:0][7:0]       pat;
		logic [PATTERN_MAX-1:0]            wild;
	} pattern_cfg_t;

	// A byte seen lag positions back from the newest byte lines up with pattern
	// byte eff_len-1-lag. Positions outside the pattern always pass.
	function automatic logic pos_ok(input logic [DIST_BITS-1:0] lag,
	                                input logic [7:0] seen,
	                                input pattern_cfg_t cfg);
		logic [LEN_BITS-1:0]  lag_w;
		logic [LEN_BITS-1:0]  idx_w;
		logic [DIST_BITS-1:0] idx;
		lag_w = {1'b0, lag};
		idx_w = cfg.eff_len - lag_w - LEN_BITS'(1);
		idx   = idx_w[DIST_BITS-1:0];
		if (lag_w >= cfg.eff_len) begin
			return 1'b1;
		end
		return cfg.wild[idx] | (seen == cfg.pat[idx]);
	endfunction

endpackage

### hdl/wbps_scan_if.sv
// Input channel carrying one scanned byte with its address and block start flag.
interface wbps_scan_if import wbps_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [7:0]              data_byte;
	logic [ADDRESS_BITS-1:0] byte_address;
	logic                    block_start;

	modport source (output valid, data_byte, byte_address, block_start, input ready);
	modport sink   (input valid, data_byte, byte_address, block_start, output ready);
endinterface

### hdl/wbps_match_if.sv
// Output channel carrying the start address of one pattern match.
interface wbps_match_if import wbps_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ADDRESS_BITS-1:0] match_address;

	modport source (output valid, match_address, input ready);
	modport sink   (input valid, match_address, output ready);
endinterface

### hdl/wbps_cell.sv
// One history cell: holds one past byte, shifts it on, and checks it against its pattern byte.
module wbps_cell import wbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift_en,
	input  logic [DIST_BITS-1:0] lag,
	input  logic [7:0]           byte_in,
	input  pattern_cfg_t         cfg,
	output logic [7:0]           byte_out,
	output logic                 ok
);

	logic [7:0] hist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (shift_en) begin
			hist_q <= byte_in;
		end
	end

	assign byte_out = hist_q;
	assign ok       = pos_ok(lag, hist_q, cfg);

endmodule

### hdl/wildcard_byte_pattern_scanner_core.sv
// Top level of the wildcard byte pattern scanner: config registers, cell chain and output stage.
//
//  Channel    Dir  Handshake       Word contents
//  scan_in    in   valid/ready     data_byte, byte_address, block_start
//  match_out  out  valid/ready     match_address
//  cfg        in   cfg_we          cfg_index, cfg_data
//
// One byte is taken per cycle while scan_in.ready is high; its match result is registered
// into the output register, or into the skid entry while match_out is stalled. The compare
// of all pattern positions against the cell chain and the address subtract feed these registers.
// Reset clears the history, the fill count and the output stage; pattern length resets to 1.
// A two-entry output stage (register plus skid) lets input flow while a match waits;
// scan_in.ready drops only when both entries are full.
module wildcard_byte_pattern_scanner_core import wbps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	wbps_scan_if.sink                 scan_in,
	wbps_match_if.source              match_out
);

	logic [LEN_BITS-1:0]      len_q;
	logic [CFG_DATA_BITS-1:0] words_q [PATTERN_WORDS];
	logic [PATTERN_MAX-1:0]   wild_q;
	pattern_cfg_t             cfg;

	logic [DIST_BITS-1:0]     fill_q;
	logic [DIST_BITS-1:0]     fill_eff;
	logic                     enough;
	logic                     acc;
	logic                     head_ok;
	logic                     hit;
	logic [ADDRESS_BITS-1:0]  match_addr_c;

	logic [7:0]               chain [HIST_DEPTH+1];
	logic [HIST_DEPTH-1:0]    cell_ok;

	logic                     out_v_q;
	logic [ADDRESS_BITS-1:0]  out_addr_q;
	logic                     skid_v_q;
	logic [ADDRESS_BITS-1:0]  skid_addr_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_BITS'(1);
			for (int w = 0; w < PATTERN_WORDS; w++) begin
				words_q[w] <= '0;
			end
			wild_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH:  len_q      <= cfg_data[LEN_BITS-1:0];
				REG_PATTERN_BYTES_A: words_q[0] <= cfg_data;
				REG_PATTERN_BYTES_B: words_q[1] <= cfg_data;
				REG_PATTERN_BYTES_C: words_q[2] <= cfg_data;
				REG_PATTERN_BYTES_D: words_q[3] <= cfg_data;
				REG_WILDCARD_MASK:   wild_q     <= cfg_data[PATTERN_MAX-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_q == '0) begin
			cfg.eff_len = LEN_BITS'(1);
		end else if (len_q > LEN_BITS'(PATTERN_MAX)) begin
			cfg.eff_len = LEN_BITS'(PATTERN_MAX);
		end else begin
			cfg.eff_len = len_q;
		end
		cfg.pat  = {words_q[3], words_q[2], words_q[1], words_q[0]};
		cfg.wild = wild_q;
	end

	// History chain: cell d holds the byte d+1 positions behind the incoming one.
	assign acc      = scan_in.valid & scan_in.ready;
	assign chain[0] = scan_in.data_byte;

	for (genvar d = 0; d < HIST_DEPTH; d++) begin : g_cell
		wbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (acc),
			.lag      (DIST_BITS'(d + 1)),
			.byte_in  (chain[d]),
			.cfg      (cfg),
			.byte_out (chain[d+1]),
			.ok       (cell_ok[d])
		);
	end

	// A block start makes the history count as empty before the new byte is checked.
	assign fill_eff     = scan_in.block_start ? '0 : fill_q;
	assign enough       = ({1'b0, fill_eff} + LEN_BITS'(1)) >= cfg.eff_len;
	assign head_ok      = pos_ok('0, scan_in.data_byte, cfg);
	assign hit          = acc & enough & head_ok & (&cell_ok);
	assign match_addr_c = scan_in.byte_address - ADDRESS_BITS'(cfg.eff_len - LEN_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (acc) begin
			if (fill_eff == DIST_BITS'(HIST_DEPTH)) begin
				fill_q <= fill_eff;
			end else begin
				fill_q <= fill_eff + DIST_BITS'(1);
			end
		end
	end

	// Output register with a skid entry behind it.
	assign scan_in.ready           = ~skid_v_q;
	assign match_out.valid         = out_v_q;
	assign match_out.match_address = out_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !match_out.ready) begin
			if (hit) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= hit;
		end else begin
			out_v_q  <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !match_out.ready) begin
			if (hit) begin
				skid_addr_q <= match_addr_c;
			end
		end else if (skid_v_q) begin
			out_addr_q <= skid_addr_q;
			if (hit) begin
				skid_addr_q <= match_addr_c;
			end
		end else if (hit) begin
			out_addr_q <= match_addr_c;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds a word while the output register is empty");

	a_start_no_long_match: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && scan_in.block_start && cfg.eff_len != LEN_BITS'(1)) |-> !hit)
		else $error("match reported across a block start");

	a_fill_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && scan_in.block_start) |=> (fill_q == DIST_BITS'(1)))
		else $error("fill count not restarted by a block start");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && out_v_q && !match_out.ready) |=> (skid_v_q && out_v_q))
		else $error("pending match word lost while output is stalled");

endmodule
